### hw/rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

	// Default number of thread slots and the fixed idle slot.
	localparam int THREAD_SLOTS_DEF = 16;
	localparam int IDLE_SLOT        = 0;

	// Function codes of a request. Code 7 is unassigned and behaves as a query.
	typedef enum logic [2:0] {
		FN_PREPARE    = 3'd0,
		FN_ENQUEUE    = 3'd1,
		FN_YIELD      = 3'd2,
		FN_BLOCK      = 3'd3,
		FN_MARK_READY = 3'd4,
		FN_TICK       = 3'd5,
		FN_QUERY      = 3'd6
	} func_t;

	// Life cycle of a thread slot.
	typedef enum logic [2:0] {
		ST_UNUSED  = 3'd0,
		ST_NEW     = 3'd1,
		ST_READY   = 3'd2,
		ST_RUNNING = 3'd3,
		ST_BLOCKED = 3'd4
	} slot_state_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		RC_OK      = 2'd0,
		RC_INVALID = 2'd1,
		RC_STATE   = 2'd2
	} status_t;

	// One request.
	typedef struct packed {
		logic [2:0] func;
		logic [3:0] thread_slot;
	} req_t;

	// One result.
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  current_thread;
		logic [4:0]  ready_total;
		logic [31:0] slot_switches;
		logic [31:0] slot_ticks;
		logic [31:0] total_switches;
		logic [31:0] total_ticks;
	} rsp_t;

	// One entry of the per-slot memory.
	typedef struct packed {
		slot_state_t state;
		logic [31:0] switches;
		logic [31:0] ticks;
	} entry_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		FS_IDLE,
		FS_EXEC,
		FS_NEXT_WR,
		FS_FETCH,
		FS_REPORT
	} fsm_t;

	// Step decisions handed from the datapath to the sequencer.
	typedef struct packed {
		logic finish;
		logic to_next;
		logic to_fetch;
	} ctl_t;

endpackage

### hw/rtl/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// Each request reads its slot entry and the ring head when it is accepted. Prepare, enqueue,
// mark ready and query then finish in the exec state, a read-modify-write of the slot memory.
// A yield or block that switches also writes the new thread's entry in the next-write state.
// A tick, yield or block that reports a slot other than the running thread then fetches and
// reports that entry. The result is registered as the sequencer returns to idle.
// Reset clears the sequencer, ring pointers, counters and slot valid bits; no clearing pass.

module round_robin_thread_scheduler
	import rrts_pkg::*;
#(
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int SW = $clog2(THREAD_SLOTS);
	localparam int CW = $clog2(THREAD_SLOTS + 1);
	localparam logic [SW-1:0] IDLE_IDX = SW'(IDLE_SLOT);
	localparam logic [SW-1:0] LAST_IDX = SW'(THREAD_SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(THREAD_SLOTS);

	// Memories: per-slot state and counters, and the ready ring.
	entry_t            entry_mem [THREAD_SLOTS];
	logic [SW-1:0]     ring_mem  [THREAD_SLOTS];
	logic [THREAD_SLOTS-1:0] valid_q;

	entry_t        rd_data_q;
	logic          rd_valid_q;
	logic          rd_idle_q;
	logic [SW-1:0] ring_rd_q;

	fsm_t          state_q, state_d;
	logic [SW-1:0] head_q, head_d, tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [SW-1:0] running_q, running_d;
	logic [31:0]   gsw_q, gsw_d, gtk_q, gtk_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q, rsp_d;

	logic [2:0]    func_q;
	logic          in_range_q;
	logic [SW-1:0] sidx_q;
	status_t       status_q, status_d;

	logic [31:0]   slot_wide;
	logic          in_range_in;
	logic [SW-1:0] sidx_in;

	logic          go;
	ctl_t          ctl;
	logic          rd_en, ring_rd_en, wr_en, ring_wr_en;
	logic [SW-1:0] rd_addr, wr_addr, ring_wr_data;
	entry_t        wr_data, rd_entry;
	logic          pop, push;
	logic [SW-1:0] next_slot;
	logic [31:0]   rep_sw, rep_tk;
	logic [31:0]   run_wide, cnt_wide;

	// Decode the slot of an incoming request.
	assign slot_wide   = 32'(req.thread_slot);
	assign in_range_in = slot_wide < 32'(THREAD_SLOTS);
	assign sidx_in     = slot_wide[SW-1:0];

	// A step that may deliver a result waits while the output register is held.
	assign go        = !(rsp_valid_q && rsp_stall);
	assign req_stall = (state_q != FS_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An entry never written reads as its reset value.
	always_comb begin
		if (rd_valid_q) begin
			rd_entry = rd_data_q;
		end else begin
			rd_entry.state    = rd_idle_q ? ST_RUNNING : ST_UNUSED;
			rd_entry.switches = '0;
			rd_entry.ticks    = '0;
		end
	end

	// Next slot to run: the head of the ring, or the idle slot when it is empty.
	assign next_slot = (count_q != '0) ? ring_rd_q : IDLE_IDX;

	// Per-slot memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= entry_mem[rd_addr];
		end
	end

	// Ready ring memory, written at the tail and read at the head.
	always_ff @(posedge clk) begin
		if (ring_wr_en) begin
			ring_mem[tail_q] <= ring_wr_data;
		end
		if (ring_rd_en) begin
			ring_rd_q <= ring_mem[head_q];
		end
	end

	// Valid bits of the per-slot memory, sampled alongside each read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_idle_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				rd_idle_q  <= (rd_addr == IDLE_IDX);
			end
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (req_valid) begin
					state_d = FS_EXEC;
				end
			end
			FS_EXEC, FS_NEXT_WR: begin
				if (go) begin
					if (ctl.finish) begin
						state_d = FS_IDLE;
					end else if (ctl.to_next) begin
						state_d = FS_NEXT_WR;
					end else if (ctl.to_fetch) begin
						state_d = FS_FETCH;
					end
				end
			end
			FS_FETCH: begin
				if (go) begin
					state_d = FS_REPORT;
				end
			end
			FS_REPORT: begin
				if (go) begin
					state_d = FS_IDLE;
				end
			end
		endcase
	end

	// Datapath: memory accesses, ring pointers, counters and the result.
	always_comb begin
		ctl          = '0;
		rd_en        = 1'b0;
		rd_addr      = running_q;
		ring_rd_en   = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = running_q;
		wr_data      = rd_entry;
		ring_wr_data = running_q;
		pop          = 1'b0;
		push         = 1'b0;
		running_d    = running_q;
		gsw_d        = gsw_q;
		gtk_d        = gtk_q;
		status_d     = status_q;
		rep_sw       = rd_entry.switches;
		rep_tk       = rd_entry.ticks;

		unique case (state_q)
			FS_IDLE: begin
				// Fetch the entry the request needs first, and the ring head.
				if (req_valid) begin
					rd_en      = 1'b1;
					ring_rd_en = 1'b1;
					case (func_t'(req.func)) inside
						FN_TICK, FN_YIELD, FN_BLOCK: rd_addr = running_q;
						default:                     rd_addr = sidx_in;
					endcase
				end
			end
			FS_EXEC: begin
				if (go) begin
					status_d = RC_OK;
					unique case (func_t'(func_q))
						FN_PREPARE: begin
							if (!in_range_q) begin
								status_d = RC_INVALID;
							end else if (sidx_q == IDLE_IDX || sidx_q == running_q ||
									rd_entry.state == ST_READY) begin
								status_d = RC_STATE;
							end else begin
								wr_en            = 1'b1;
								wr_addr          = sidx_q;
								wr_data.state    = ST_NEW;
								wr_data.switches = '0;
								wr_data.ticks    = '0;
							end
							rep_sw     = wr_data.switches;
							rep_tk     = wr_data.ticks;
							ctl.finish = 1'b1;
						end
						FN_ENQUEUE, FN_MARK_READY: begin
							if (!in_range_q || rd_entry.state == ST_UNUSED) begin
								status_d = RC_INVALID;
							end else if (func_t'(func_q) == FN_MARK_READY &&
									rd_entry.state != ST_BLOCKED) begin
								status_d = RC_STATE;
							end else if (rd_entry.state != ST_NEW &&
									rd_entry.state != ST_BLOCKED) begin
								status_d = RC_STATE;
							end else if (count_q == FULL_CNT) begin
								status_d = RC_STATE;
							end else begin
								wr_en         = 1'b1;
								wr_addr       = sidx_q;
								wr_data.state = ST_READY;
								push          = 1'b1;
								ring_wr_data  = sidx_q;
							end
							ctl.finish = 1'b1;
						end
						FN_TICK: begin
							gtk_d         = gtk_q + 32'd1;
							wr_en         = 1'b1;
							wr_addr       = running_q;
							wr_data.ticks = rd_entry.ticks + 32'd1;
							if (!in_range_q || sidx_q == running_q) begin
								rep_tk     = wr_data.ticks;
								ctl.finish = 1'b1;
							end else begin
								ctl.to_fetch = 1'b1;
							end
						end
						FN_YIELD, FN_BLOCK: begin
							if ((func_t'(func_q) == FN_BLOCK && running_q == IDLE_IDX) ||
									next_slot == running_q) begin
								// No switch: blocking the idle thread, or idle stays.
								if (func_t'(func_q) == FN_BLOCK) begin
									status_d = RC_STATE;
								end
								if (!in_range_q || sidx_q == running_q) begin
									ctl.finish = 1'b1;
								end else begin
									ctl.to_fetch = 1'b1;
								end
							end else begin
								// Retire the old thread and start reading the new one.
								pop              = (count_q != '0);
								wr_en            = 1'b1;
								wr_addr          = running_q;
								wr_data.switches = rd_entry.switches + 32'd1;
								if (func_t'(func_q) == FN_BLOCK) begin
									wr_data.state = ST_BLOCKED;
								end else if (running_q != IDLE_IDX) begin
									wr_data.state = ST_READY;
									push          = 1'b1;
									ring_wr_data  = running_q;
								end
								rd_en       = 1'b1;
								rd_addr     = next_slot;
								running_d   = next_slot;
								gsw_d       = gsw_q + 32'd1;
								ctl.to_next = 1'b1;
							end
						end
						default: begin
							status_d   = in_range_q ? RC_OK : RC_INVALID;
							ctl.finish = 1'b1;
						end
					endcase
				end
			end
			FS_NEXT_WR: begin
				// The new thread runs and counts a switch.
				if (go) begin
					wr_en            = 1'b1;
					wr_addr          = running_q;
					wr_data.state    = ST_RUNNING;
					wr_data.switches = rd_entry.switches + 32'd1;
					if (!in_range_q || sidx_q == running_q) begin
						rep_sw     = wr_data.switches;
						ctl.finish = 1'b1;
					end else begin
						ctl.to_fetch = 1'b1;
					end
				end
			end
			FS_FETCH: begin
				if (go) begin
					rd_en   = 1'b1;
					rd_addr = sidx_q;
				end
			end
			FS_REPORT: begin
				if (go) begin
					ctl.finish = 1'b1;
				end
			end
		endcase

		// Ring pointers and fill count.
		ring_wr_en = push;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		if (pop) begin
			head_d = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		end
		if (push) begin
			tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
		end
		case ({push, pop})
			2'b10:   count_d = count_q + 1'b1;
			2'b01:   count_d = count_q - 1'b1;
			default: count_d = count_q;
		endcase

		// Assemble the result from the state after this request.
		run_wide           = 32'(running_d);
		cnt_wide           = 32'(count_d);
		rsp_d.status         = status_d;
		rsp_d.current_thread = run_wide[3:0];
		rsp_d.ready_total    = cnt_wide[4:0];
		rsp_d.slot_switches  = in_range_q ? rep_sw : '0;
		rsp_d.slot_ticks     = in_range_q ? rep_tk : '0;
		rsp_d.total_switches = gsw_d;
		rsp_d.total_ticks    = gtk_d;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			running_q   <= IDLE_IDX;
			gsw_q       <= '0;
			gtk_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			running_q <= running_d;
			gsw_q     <= gsw_d;
			gtk_q     <= gtk_d;
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, status and the result register.
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && req_valid) begin
			func_q     <= req.func;
			in_range_q <= in_range_in;
			sidx_q     <= sidx_in;
		end
		status_q <= status_d;
		if (ctl.finish) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
